@@ rtl/lscr_pkg.sv @@
// shared types, constants and tables for the laser scan raycaster
`timescale 1ns / 1ps
package lscr_pkg;

  // default sizes
  localparam int MAX_OBSTACLES_DEF = 16;
  localparam int MAX_BEAMS_DEF     = 64;

  // register indexes on the configuration port
  localparam logic REG_BEAM_COUNT = 1'b0;
  localparam logic REG_MAX_RANGE  = 1'b1;

  // item kinds
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_SCAN  = 2'd2;

  // register reset values
  localparam logic [6:0]  BEAM_COUNT_RST = 7'd16;
  localparam logic [23:0] MAX_RANGE_RST  = 24'd655360;
  localparam logic [6:0]  MIN_BEAMS      = 7'd4;

  // obstacles this far off on either axis can never be hit
  localparam logic signed [32:0] FAR_LIMIT = 33'sd33554432;

  // cordic setup
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_BEAM, ST_CORDIC, ST_RD, ST_DIFF, ST_FAR,
    ST_DYS, ST_DXX, ST_DYY, ST_RR, ST_PP, ST_DISC, ST_SQRT,
    ST_NEAR, ST_FARX, ST_NEXT, ST_OUT
  } lscr_state_t;

endpackage

@@ rtl/lscr_ram.sv @@
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
module lscr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lscr_cordic.sv @@
// iterative cordic: beam angle to cos/sin in q1.30
`timescale 1ns / 1ps
module lscr_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        ang,
  output logic               done,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import lscr_pkg::*;

  logic signed [33:0] x, y, z;
  logic [1:0]  quad;
  logic [3:0]  k;
  logic        run;
  logic [1:0]  quad_in;
  logic [15:0] resid;
  logic signed [33:0] xs, ys, at;

  // quadrant fold into [-1/8, 1/8) turn
  always_comb begin
    quad_in = 2'((ang + 16'h2000) >> 14);
    resid   = ang - {quad_in, 14'd0};
    xs      = x >>> k;
    ys      = y >>> k;
    at      = {2'b00, ATAN_TURNS[k]};
  end

  // one micro-rotation per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= run && (k == 4'(CORDIC_STEPS - 1));
      if (start) begin
        run  <= 1'b1;
        k    <= '0;
        quad <= quad_in;
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= {{2{resid[15]}}, resid, 16'd0};
      end else if (run) begin
        if (!z[33]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        k <= k + 4'd1;
        if (k == 4'(CORDIC_STEPS - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // undo the quadrant fold
  always_comb begin
    case (quad)
      2'd0:    begin cos_o = x[31:0];    sin_o = y[31:0];    end
      2'd1:    begin cos_o = -y[31:0];   sin_o = x[31:0];    end
      2'd2:    begin cos_o = -x[31:0];   sin_o = -y[31:0];   end
      default: begin cos_o = y[31:0];    sin_o = -x[31:0];   end
    endcase
  end

endmodule

@@ rtl/lscr_sqrt.sv @@
// bitwise integer square root, one result bit per cycle
`timescale 1ns / 1ps
module lscr_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v, res, bitv, trial;
  logic        run;

  assign trial = res + bitv;
  assign root  = res[31:0];

  // restoring root step
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (bitv == 64'd1);
      if (start) begin
        run  <= 1'b1;
        v    <= value;
        res  <= '0;
        bitv <= 64'd1 << 62;
      end else if (run) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 64'd1) begin
          run <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/laser_scan_circle_raycast.sv @@
// top level: obstacle table, scan sequencer and beam output register
//
// Simulated 2-D laser scanner over a table of circles held in a ram.
// Input words (s_*): tuser carries the op (clear, add, scan); tdata the
// x, y, radius and heading. A scan emits one output word (m_*) per beam
// with the beam index, range and hit flag; tlast marks the final beam.
// Scan steps: the beam step division, then per beam the cordic start,
// the cordic rotation and the output load, with per stored obstacle a
// ram read, six shared-multiplier steps and the square root; an obstacle
// with a negative discriminant skips the root, and one that is too far
// off skips all but the ram read and the distance check.
// The block takes a new input word only between scans.
// A finished beam waits in the output register; the next beam is computed
// meanwhile, and the sequencer only holds when a second beam is ready
// before the first is taken.
// Reset empties the table, sets beam_count to 16, max_range to 10.0 and
// drops any pending output word.
// Config (cfg_*) writes are taken any time the block is idle.
`timescale 1ns / 1ps
module laser_scan_circle_raycast #(
  parameter int MAX_OBSTACLES = lscr_pkg::MAX_OBSTACLES_DEF,
  parameter int MAX_BEAMS     = lscr_pkg::MAX_BEAMS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // item_x, item_y, obstacle_radius, robot_heading
  input  logic [1:0]   s_tuser,   // op
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // beam_index, beam_range
  output logic         m_tuser,   // hit
  output logic         m_tlast,   // last_beam
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [23:0]  cfg_data
);
  import lscr_pkg::*;

  localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CW = $clog2(MAX_OBSTACLES + 1);

  lscr_state_t state, state_next;

  // config registers
  logic [6:0]  beam_count;
  logic [23:0] max_range;

  // table
  logic [CW-1:0] obs_count;
  logic          ram_we;
  logic [87:0]   ram_rdata;
  logic [AW-1:0] obs_idx;

  // scan state
  logic signed [31:0] px, py;
  logic [15:0] heading;
  logic [6:0]  n, beam;
  logic [6:0]  div_rem;
  logic [16:0] div_quot, step_q, q_acc;
  logic [4:0]  div_cnt;
  logic [6:0]  step_r, rem_acc;
  logic signed [31:0] cs, sn;
  logic signed [32:0] dx, dy;
  logic [23:0] rad;
  logic signed [63:0] prod, acc, disc, rnd_sum;
  logic signed [33:0] p;
  logic [31:0] h;
  logic [23:0] closest;
  logic        hit_f;

  // datapath helpers
  logic        in_acc, out_load, far;
  logic [7:0]  rem_sh;
  logic [7:0]  rem_sum;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_res;
  logic signed [35:0] t_near, t_far;
  logic        near_ok, far_ok;
  logic [CW-1:0] idx_next;
  logic        cor_start, cor_done, sq_start, sq_done;
  logic signed [31:0] cor_c, cor_s;
  logic [31:0] sq_root;
  logic [6:0]  n_eff;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);
  assign ram_we   = in_acc && (s_tuser == OP_ADD) && (obs_count < CW'(MAX_OBSTACLES));
  assign idx_next = CW'(obs_idx) + CW'(1);
  assign rem_sh   = {div_rem, (div_cnt == 5'd16)};
  assign rem_sum  = {1'b0, rem_acc} + {1'b0, step_r};
  assign rnd_sum  = acc + prod + 64'sd536870912;
  assign disc     = acc + prod;
  assign far      = (dx >= FAR_LIMIT) || (dx <= -FAR_LIMIT) ||
                    (dy >= FAR_LIMIT) || (dy <= -FAR_LIMIT);
  assign mul_res  = mul_a * mul_b;
  assign cor_start = (state == ST_BEAM);
  assign sq_start  = (state == ST_DISC) && !disc[63];
  assign t_near   = 36'(p) - $signed({4'd0, h});
  assign t_far    = 36'(p) + $signed({4'd0, h});
  assign near_ok  = (t_near > 36'sd0) && (t_near < $signed({12'd0, max_range})) &&
                    (t_near < $signed({12'd0, closest}));
  assign far_ok   = (t_far > 36'sd0) && (t_far < $signed({12'd0, max_range})) &&
                    (t_far < $signed({12'd0, closest}));

  // effective beam count
  always_comb begin
    if (beam_count < MIN_BEAMS) begin
      n_eff = MIN_BEAMS;
    end else if (beam_count > 7'(MAX_BEAMS)) begin
      n_eff = 7'(MAX_BEAMS);
    end else begin
      n_eff = beam_count;
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      ST_FAR:  begin mul_a = dx[31:0];          mul_b = cs;            end
      ST_DYS:  begin mul_a = dy[31:0];          mul_b = sn;            end
      ST_DXX:  begin mul_a = dx[31:0];          mul_b = dx[31:0];      end
      ST_DYY:  begin mul_a = dy[31:0];          mul_b = dy[31:0];      end
      ST_RR:   begin mul_a = {8'd0, rad};       mul_b = {8'd0, rad};   end
      default: begin mul_a = p[31:0];           mul_b = p[31:0];       end
    endcase
  end

  lscr_ram #(.WIDTH(88), .DEPTH(MAX_OBSTACLES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (obs_count[AW-1:0]),
    .wdata ({s_tdata[87:64], s_tdata[63:32], s_tdata[31:0]}),
    .raddr (obs_idx),
    .rdata (ram_rdata)
  );

  lscr_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .ang   (heading + 16'h8000 + q_acc[15:0]),
    .done  (cor_done),
    .cos_o (cor_c),
    .sin_o (cor_s)
  );

  lscr_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (disc),
    .done  (sq_done),
    .root  (sq_root)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc && s_tuser == OP_SCAN) state_next = ST_DIV;
      ST_DIV:    if (div_cnt == 5'd0) state_next = ST_BEAM;
      ST_BEAM:   state_next = ST_CORDIC;
      ST_CORDIC: if (cor_done) state_next = (obs_count == '0) ? ST_OUT : ST_RD;
      ST_RD:     state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_FAR;
      ST_FAR:    state_next = far ? ST_NEXT : ST_DYS;
      ST_DYS:    state_next = ST_DXX;
      ST_DXX:    state_next = ST_DYY;
      ST_DYY:    state_next = ST_RR;
      ST_RR:     state_next = ST_PP;
      ST_PP:     state_next = ST_DISC;
      ST_DISC:   state_next = disc[63] ? ST_NEXT : ST_SQRT;
      ST_SQRT:   if (sq_done) state_next = ST_NEAR;
      ST_NEAR:   state_next = ST_FARX;
      ST_FARX:   state_next = ST_NEXT;
      ST_NEXT:   state_next = (idx_next == obs_count) ? ST_OUT : ST_RD;
      ST_OUT:    if (out_load) state_next = (beam == n - 7'd1) ? ST_IDLE : ST_BEAM;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control registers: config, table fill, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_count <= BEAM_COUNT_RST;
      max_range  <= MAX_RANGE_RST;
      obs_count  <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_BEAM_COUNT: beam_count <= cfg_data[6:0];
          REG_MAX_RANGE:  max_range  <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && s_tuser == OP_CLEAR) begin
        obs_count <= '0;
      end else if (ram_we) begin
        obs_count <= obs_count + CW'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        px       <= $signed(s_tdata[31:0]);
        py       <= $signed(s_tdata[63:32]);
        heading  <= s_tdata[103:88];
        n        <= n_eff;
        div_rem  <= '0;
        div_quot <= '0;
        div_cnt  <= 5'd16;
        beam     <= '0;
        q_acc    <= '0;
        rem_acc  <= '0;
      end
      ST_DIV: begin
        // restoring division of one turn by the beam count
        if (rem_sh >= {1'b0, n}) begin
          div_rem  <= 7'(rem_sh - {1'b0, n});
          div_quot <= {div_quot[15:0], 1'b1};
        end else begin
          div_rem  <= rem_sh[6:0];
          div_quot <= {div_quot[15:0], 1'b0};
        end
        div_cnt <= div_cnt - 5'd1;
      end
      ST_BEAM: begin
        step_q  <= div_quot;
        step_r  <= div_rem;
        closest <= max_range;
        hit_f   <= 1'b0;
        obs_idx <= '0;
      end
      ST_CORDIC: begin
        cs <= cor_c;
        sn <= cor_s;
      end
      ST_DIFF: begin
        dx  <= 33'(signed'(ram_rdata[31:0])) - 33'(px);
        dy  <= 33'(signed'(ram_rdata[63:32])) - 33'(py);
        rad <= ram_rdata[87:64];
      end
      ST_FAR: prod <= mul_res;
      ST_DYS: begin
        acc  <= prod;
        prod <= mul_res;
      end
      ST_DXX: begin
        p    <= 34'(rnd_sum >>> 30);
        prod <= mul_res;
      end
      ST_DYY: begin
        acc  <= prod;
        prod <= mul_res;
      end
      ST_RR: begin
        acc  <= acc + prod;
        prod <= mul_res;
      end
      ST_PP: begin
        acc  <= prod - acc;
        prod <= mul_res;
      end
      ST_SQRT: h <= sq_root;
      ST_NEAR: begin
        if (near_ok) begin
          closest <= t_near[23:0];
          hit_f   <= 1'b1;
        end
      end
      ST_FARX: begin
        if (far_ok) begin
          closest <= t_far[23:0];
          hit_f   <= 1'b1;
        end
      end
      ST_NEXT: obs_idx <= idx_next[AW-1:0];
      ST_OUT: begin
        if (out_load) begin
          m_tdata <= {2'b00, closest, beam[5:0]};
          m_tuser <= hit_f;
          m_tlast <= (beam == n - 7'd1);
          beam    <= beam + 7'd1;
          // next beam angle offset, floor(i * turn / n)
          if (rem_sum >= {1'b0, n}) begin
            rem_acc <= 7'(rem_sum - {1'b0, n});
            q_acc   <= q_acc + step_q + 17'd1;
          end else begin
            rem_acc <= rem_sum[6:0];
            q_acc   <= q_acc + step_q;
          end
        end
      end
      default: ;
    endcase
  end

  // table fill never passes its depth
  assert property (@(posedge clk) disable iff (rst)
    obs_count <= CW'(MAX_OBSTACLES))
    else $error("obstacle count beyond table depth");

  // the final beam of a scan returns the sequencer to idle
  assert property (@(posedge clk) disable iff (rst)
    (out_load && beam == n - 7'd1) |=> (state == ST_IDLE && m_tvalid && m_tlast))
    else $error("scan did not end on its last beam");

  // the root unit only starts on a nonnegative discriminant
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT && $past(state) == ST_DISC) |-> !$past(disc[63]))
    else $error("square root started on negative value");

endmodule

@@ bench/tb.sv @@
// self-checking bench for the laser scan raycaster: stream driver, beam checker, range predictor
`timescale 1ns / 1ps
module tb;
  import lscr_pkg::*;

  localparam int  NUM_OBS     = 16;
  localparam int  NUM_BEAMS   = 64;
  localparam int  LIMIT       = 30000000;
  localparam int  SETTLE      = 60;
  localparam longint FAR_DIST = 64'sd33554432;
  localparam longint GAIN     = 64'sd652032874;
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [23:0]        r;
    logic [15:0]        hd;
  } scan_item_t;

  typedef struct {
    logic [5:0]  idx;
    logic [23:0] rng;
    logic        hit;
    logic        last;
  } beam_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [103:0] s_tdata;   // item_x, item_y, obstacle_radius, robot_heading
  logic [1:0]   s_tuser;   // op
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;   // beam_index, beam_range
  logic         m_tuser;   // hit
  logic         m_tlast;   // last_beam
  logic         cfg_we;
  logic         cfg_addr;
  logic [23:0]  cfg_data;

  laser_scan_circle_raycast dut (.*);

  // stimulus and expectation stores
  scan_item_t pending_items[$];
  beam_t      expected_beams[$];
  int         errors = 0;
  int         beams_seen = 0;
  int         scans_sent = 0;
  int         hits_seen = 0;
  logic       long_hold_req = 1'b0;

  // predictor state
  longint     obs_x[NUM_OBS];
  longint     obs_y[NUM_OBS];
  longint     obs_r[NUM_OBS];
  int         obs_n;
  int         beams_cfg;
  longint     range_cfg;

  longint atan_tab[16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861
  };

  // bitwise integer square root
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // beam direction as q1.30 cos and sin
  task automatic beam_dir(input logic [15:0] ang, output longint c, output longint s);
    logic [1:0]  q;
    logic [15:0] resid;
    longint      x, y, z, xs, ys;
    q = 2'((ang + 16'h2000) >> 14);
    resid = ang - {q, 14'd0};
    z = longint'($signed(resid)) * 65536;
    x = GAIN;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_tab[i];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_tab[i];
      end
    end
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // update the obstacle table, or queue the ranges a scan must report
  task automatic predict_item(input scan_item_t it);
    int          n;
    logic [15:0] ang;
    longint      c, s, best, dx, dy, p, disc, h, t;
    logic        hit;
    beam_t       b;
    case (it.op)
      OP_CLEAR: obs_n = 0;
      OP_ADD: if (obs_n < NUM_OBS) begin
        obs_x[obs_n] = it.x;
        obs_y[obs_n] = it.y;
        obs_r[obs_n] = it.r;
        obs_n++;
      end
      OP_SCAN: begin
        scans_sent++;
        n = beams_cfg < 4 ? 4 : (beams_cfg > NUM_BEAMS ? NUM_BEAMS : beams_cfg);
        for (int i = 0; i < n; i++) begin
          ang = it.hd + 16'h8000 + 16'((i * 65536) / n);
          beam_dir(ang, c, s);
          best = range_cfg;
          hit = 1'b0;
          for (int o = 0; o < obs_n; o++) begin
            dx = obs_x[o] - longint'(it.x);
            dy = obs_y[o] - longint'(it.y);
            if (dx >= FAR_DIST || dx <= -FAR_DIST || dy >= FAR_DIST || dy <= -FAR_DIST)
              continue;
            p = (dx * c + dy * s + (64'sd1 << 29)) >>> 30;
            disc = obs_r[o] * obs_r[o] - (dx * dx + dy * dy) + p * p;
            if (disc < 0) continue;
            h = longint'(isqrt(disc));
            for (int k = 0; k < 2; k++) begin
              t = k == 0 ? p - h : p + h;
              if (t > 0 && t < range_cfg && t < best) begin
                best = t;
                hit = 1'b1;
              end
            end
          end
          b.idx = 6'(i);
          b.rng = 24'(best);
          b.hit = hit;
          b.last = (i == n - 1);
          expected_beams = {expected_beams, b};
        end
      end
      default: ;
    endcase
  endtask

  // clock and timeout
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  longint cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout with %0d beams still expected", expected_beams.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // driver: bursts of words with random gaps
  int burst_left = 0;
  int gap_left = 0;
  scan_item_t cur_item;
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= OP_CLEAR;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) predict_item(cur_item);
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        nv = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 6);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      s_tvalid <= nv;
      s_tdata  <= {cur_item.hd, cur_item.r, cur_item.y, cur_item.x};
      s_tuser  <= cur_item.op;
    end
  end

  // receiver: random stall pattern, plus one long hold-off on request
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 2500;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if ((cycles / 512) % 3 == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // checker: each beam word against the oldest expectation
  always @(posedge clk) begin
    beam_t b;
    if (!rst && m_tvalid && m_tready) begin
      beams_seen++;
      if (m_tuser) hits_seen++;
      if (expected_beams.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beam word %h", m_tdata);
      end else begin
        b = expected_beams.pop_front();
        if (m_tdata[5:0] !== b.idx || m_tdata[29:6] !== b.rng || m_tdata[31:30] !== 2'b00
            || m_tuser !== b.hit || m_tlast !== b.last) begin
          errors++;
          if (errors <= 10)
            $display({"beam mismatch: exp idx %0d range %0d hit %0d last %0d, ",
                      "got idx %0d range %0d hit %0d last %0d"},
                     b.idx, b.rng, b.hit, b.last, m_tdata[5:0], m_tdata[29:6],
                     m_tuser, m_tlast);
        end
      end
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] r,
                           input logic [31:0] hd);
    scan_item_t it;
    it.op = op; it.x = $signed(x); it.y = $signed(y); it.r = r[23:0]; it.hd = hd[15:0];
    pending_items = {pending_items, it};
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || s_tvalid || expected_beams.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [23:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= val;
    if (addr == REG_BEAM_COUNT) beams_cfg = val[6:0];
    else range_cfg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed clear/add/scan sequences around a robot pose, some noise
  task automatic random_items(input int count, input int max_obs, input bit allow_fill);
    int made, k;
    logic signed [31:0] rx, ry;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 8) begin
        rx = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        ry = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        if ($urandom_range(0, 3) != 0) begin
          push_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
          made++;
        end
        k = (allow_fill && $urandom_range(0, 5) == 0) ? NUM_OBS + 2
                                                      : $urandom_range(0, max_obs);
        for (int i = 0; i < k; i++) begin
          push_item(OP_ADD, rx + $signed($urandom_range(0, 32'h10_0000)) - 32'sh8_0000,
                    ry + $signed($urandom_range(0, 32'h10_0000)) - 32'sh8_0000,
                    $urandom_range(32'h4000, 32'h4_0000), $urandom);
          made++;
        end
        push_item(OP_SCAN, rx, ry, $urandom, $urandom);
        made++;
      end else begin
        case ($urandom_range(0, 2))
          0: push_item(OP_NOP, $urandom, $urandom, $urandom, $urandom);
          1: if (!allow_fill) push_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
             else push_item(OP_ADD, $urandom, $urandom, $urandom, $urandom);
          default: push_item(OP_SCAN, $urandom, $urandom, $urandom, $urandom);
        endcase
        made++;
      end
    end
  endtask

  initial begin
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_addr = REG_BEAM_COUNT;
    cfg_data = '0;
    obs_n = 0;
    beams_cfg = BEAM_COUNT_RST;
    range_cfg = MAX_RANGE_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, tangent, inside, far, extremes, full table
    push_item(OP_SCAN, 0, 0, 0, 16'h0000);
    push_item(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
    push_item(OP_ADD, 32'sh0003_0000, 0, 24'h1_0000, 0);
    push_item(OP_ADD, 0, 32'sh0003_0000, 24'h3_0000, 0);
    push_item(OP_ADD, 32'sh4000_0000, 0, 24'h1_0000, 0);
    push_item(OP_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF, 24'hFF_FFFF, 0);
    push_item(OP_SCAN, 0, 0, 0, 16'h8000);
    push_item(OP_SCAN, 0, 0, 0, 16'hFFFF);
    push_item(OP_CLEAR, 0, 0, 0, 0);
    push_item(OP_ADD, 32'sh0001_0000, 32'shFFFF_0000, 24'h2_0000, 0);
    push_item(OP_SCAN, 32'sh0001_8000, 32'shFFFF_0000, 0, 16'h1234);
    push_item(OP_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < NUM_OBS + 1; i++)
      push_item(OP_ADD, 32'sh0002_0000 * (i % 4 + 1), 32'sh0002_0000 * (i / 4) - 32'sh4_0000,
                24'h8000, 0);
    push_item(OP_SCAN, 0, 0, 0, 16'h4000);
    random_items(30, 4, 1'b1);
    wait_idle();

    // minimum beams, zero range
    write_reg(REG_BEAM_COUNT, 24'd0);
    write_reg(REG_MAX_RANGE, 24'd0);
    random_items(15, 5, 1'b1);
    wait_idle();

    // most beams, widest range, long receiver hold-off
    write_reg(REG_BEAM_COUNT, 24'd64);
    write_reg(REG_MAX_RANGE, 24'hFF_FFFF);
    @(posedge clk);
    long_hold_req <= 1'b1;
    random_items(15, 3, 1'b0);
    wait_idle();

    write_reg(REG_BEAM_COUNT, 24'd3);
    write_reg(REG_MAX_RANGE, 24'($urandom_range(0, 24'hFF_FFFF)));
    random_items(25, 6, 1'b1);
    wait_idle();

    write_reg(REG_BEAM_COUNT, 24'd37);
    write_reg(REG_MAX_RANGE, 24'h08_0000);
    random_items(25, 3, 1'b0);
    wait_idle();

    repeat (200) @(posedge clk);
    $display("covered %0d scans, %0d beam words (%0d hits) over five register settings",
             scans_sent, beams_seen, hits_seen);
    $display("beam counts 16, 0, 64, 3, 37; ranges 10.0, 0, max, random, 8.0");
    if (errors == 0 && expected_beams.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches, %0d beams missing", errors, expected_beams.size());
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
